FILE: hw/rtl/c2s_pkg.sv
// Shared constants and the CORDIC stage angle table for the converter.
package c2s_pkg;

    localparam int GUARD_BITS = 8;
    localparam int GROW_BITS = 4;
    localparam int ACC_BITS = 64;
    localparam int GAIN_BITS = 32;
    localparam logic [GAIN_BITS-1:0] GAIN_Q32 = 32'd2608131496;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [ACC_BITS-1:0] HALF_TURN = 64'h8000_0000_0000_0000;
    localparam logic [ACC_BITS-1:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
    localparam logic [ACC_BITS-1:0] EIGHTH_TURN = 64'h2000_0000_0000_0000;

    // atan(2^-i) as a fraction of a turn, 2^64 units per turn
    function automatic logic [ACC_BITS-1:0] stage_angle(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        logic [127:0] prod;
        int unsigned k;
        sum = '0;
        if (i == 0) begin
            return EIGHTH_TURN;
        end
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        prod = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
        return prod[125:62];
    endfunction

endpackage

FILE: hw/rtl/c2s_vec_stage.sv
// One registered CORDIC vectoring stage with valid and sideband.
module c2s_vec_stage import c2s_pkg::*; #(
    parameter int DW = 36,
    parameter int SHIFT = 0,
    parameter int SW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic [ACC_BITS-1:0]  i_acc,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic [ACC_BITS-1:0]  o_acc,
    output logic [SW-1:0]        o_side
);

    localparam logic [ACC_BITS-1:0] ANGLE = stage_angle(SHIFT);

    logic                 r_valid;
    logic signed [DW-1:0] r_x, r_y, n_x, n_y;
    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [SW-1:0]        r_side;
    logic signed [DW-1:0] xs, ys;

    assign xs = i_x >>> SHIFT;
    assign ys = i_y >>> SHIFT;

    always_comb begin
        if (!i_y[DW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_acc = i_acc + ANGLE;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_acc = i_acc - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_acc <= n_acc;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_acc = r_acc;
    assign o_side = r_side;

endmodule

FILE: hw/rtl/c2s_gain.sv
// Registered CORDIC gain compensation, rounded half up.
module c2s_gain import c2s_pkg::*; #(
    parameter int DW = 36,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_v,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_v,
    output logic [SW-1:0] o_side
);

    localparam int PW = DW + GAIN_BITS;

    logic          r_valid;
    logic [DW-1:0] r_v;
    logic [SW-1:0] r_side;
    logic [PW-1:0] prod;

    assign prod = PW'(i_v) * PW'(GAIN_Q32) + (PW'(1) << (GAIN_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_v <= prod[PW-1:GAIN_BITS];
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_v = r_v;
    assign o_side = r_side;

endmodule

FILE: hw/rtl/cartesian_to_spherical_cordic_unit.sv
// Top level: pipelined Cartesian to spherical conversion with two CORDIC passes.
//
// Usage: drive i_x_coord, i_y_coord, i_z_coord and raise start; the point is
// transferred at a rising edge where start is high and busy is low. busy is
// high only while reset is applied and for the first cycle after it, so a new
// point can be transferred in every cycle after that.
// The result appears on o_radius, o_polar_angle and o_azimuth for exactly one
// cycle, marked by o_valid. Throughput is one point per cycle, as the pipeline
// is fully unrolled: one input register, CORDIC_STAGES vectoring stages for the
// azimuth pass, one gain multiply, CORDIC_STAGES stages for the polar pass, one
// gain multiply and one output register.
// Results leave in transfer order; the receiver cannot stall, and no result is
// held back. A synchronous reset drops every point in flight.
// Angles are binary fractions of a turn: 2^ANGLE_BITS units per turn.
module cartesian_to_spherical_cordic_unit import c2s_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic [COORD_BITS-1:0] i_z_coord,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_radius,
    output logic [ANGLE_BITS-1:0] o_polar_angle,
    output logic [ANGLE_BITS-1:0] o_azimuth
);

    localparam int DW = COORD_BITS + GUARD_BITS + GROW_BITS;
    localparam int SW1 = 3 + COORD_BITS;
    localparam int SW2 = SW1 + ACC_BITS;
    localparam int LATENCY = 2 * CORDIC_STAGES + 4;

    // sideband: {xy_zero, z_neg, z_zero, abs_z}
    logic                  r_busy;
    logic                  r_p_valid;
    logic signed [DW-1:0]  r_p_x, r_p_y;
    logic [ACC_BITS-1:0]   r_p_az;
    logic [SW1-1:0]        r_p_side;

    logic signed [DW-1:0]  x_ext, y_ext, z_ext, z_abs;
    logic                  x_neg;

    assign x_ext = DW'($signed(i_x_coord));
    assign y_ext = DW'($signed(i_y_coord));
    assign z_ext = DW'($signed(i_z_coord));
    assign x_neg = i_x_coord[COORD_BITS-1];
    assign z_abs = z_ext[DW-1] ? -z_ext : z_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_p_valid <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_p_valid <= start && !r_busy;
        end
        r_p_x <= (x_neg ? -x_ext : x_ext) <<< GUARD_BITS;
        r_p_y <= (x_neg ? -y_ext : y_ext) <<< GUARD_BITS;
        r_p_az <= x_neg ? HALF_TURN : '0;
        r_p_side <= {(i_x_coord == '0) && (i_y_coord == '0), z_ext[DW-1],
                     i_z_coord == '0, z_abs[COORD_BITS-1:0]};
    end

    assign busy = r_busy;

    // azimuth pass
    logic                  a_valid [0:CORDIC_STAGES];
    logic signed [DW-1:0]  a_x     [0:CORDIC_STAGES];
    logic signed [DW-1:0]  a_y     [0:CORDIC_STAGES];
    logic [ACC_BITS-1:0]   a_acc   [0:CORDIC_STAGES];
    logic [SW1-1:0]        a_side  [0:CORDIC_STAGES];

    assign a_valid[0] = r_p_valid;
    assign a_x[0] = r_p_x;
    assign a_y[0] = r_p_y;
    assign a_acc[0] = r_p_az;
    assign a_side[0] = r_p_side;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_az
        c2s_vec_stage #(.DW(DW), .SHIFT(g), .SW(SW1)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (a_valid[g]),
            .i_x     (a_x[g]),
            .i_y     (a_y[g]),
            .i_acc   (a_acc[g]),
            .i_side  (a_side[g]),
            .o_valid (a_valid[g+1]),
            .o_x     (a_x[g+1]),
            .o_y     (a_y[g+1]),
            .o_acc   (a_acc[g+1]),
            .o_side  (a_side[g+1])
        );
    end

    logic           g1_valid;
    logic [DW-1:0]  g1_rho;
    logic [SW2-1:0] g1_side;

    c2s_gain #(.DW(DW), .SW(SW2)) u_gain_rho (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid[CORDIC_STAGES]),
        .i_v     (a_x[CORDIC_STAGES]),
        .i_side  ({a_side[CORDIC_STAGES], a_acc[CORDIC_STAGES]}),
        .o_valid (g1_valid),
        .o_v     (g1_rho),
        .o_side  (g1_side)
    );

    // polar pass
    logic                  b_valid [0:CORDIC_STAGES];
    logic signed [DW-1:0]  b_x     [0:CORDIC_STAGES];
    logic signed [DW-1:0]  b_y     [0:CORDIC_STAGES];
    logic [ACC_BITS-1:0]   b_acc   [0:CORDIC_STAGES];
    logic [SW2-1:0]        b_side  [0:CORDIC_STAGES];

    assign b_valid[0] = g1_valid;
    assign b_x[0] = DW'(g1_side[ACC_BITS +: COORD_BITS]) << GUARD_BITS;
    assign b_y[0] = g1_rho;
    assign b_acc[0] = '0;
    assign b_side[0] = g1_side;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pol
        c2s_vec_stage #(.DW(DW), .SHIFT(g), .SW(SW2)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_valid[g]),
            .i_x     (b_x[g]),
            .i_y     (b_y[g]),
            .i_acc   (b_acc[g]),
            .i_side  (b_side[g]),
            .o_valid (b_valid[g+1]),
            .o_x     (b_x[g+1]),
            .o_y     (b_y[g+1]),
            .o_acc   (b_acc[g+1]),
            .o_side  (b_side[g+1])
        );
    end

    logic                g2_valid;
    logic [DW-1:0]       g2_r;
    logic [SW2-1:0]      g2_side;
    logic [ACC_BITS-1:0] g2_u;

    c2s_gain #(.DW(DW), .SW(SW2)) u_gain_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid[CORDIC_STAGES]),
        .i_v     (b_x[CORDIC_STAGES]),
        .i_side  (b_side[CORDIC_STAGES]),
        .o_valid (g2_valid),
        .o_v     (g2_r),
        .o_side  (g2_side)
    );

    // g2_side = {xy_zero, z_neg, z_zero, abs_z, azimuth}; polar angle rides in b_acc
    logic [ACC_BITS-1:0] r_u;

    always_ff @(posedge i_clk) begin
        r_u <= b_acc[CORDIC_STAGES];
    end

    assign g2_u = r_u;

    logic                  f_xy_zero, f_z_neg, f_z_zero;
    logic [COORD_BITS-1:0] f_abs_z;
    logic [ACC_BITS-1:0]   f_az, f_clamp, f_theta, f_az_rnd, f_th_rnd;
    logic [DW-1:0]         f_rad;
    logic [COORD_BITS-1:0] n_radius;
    logic [ANGLE_BITS-1:0] n_polar, n_azim;

    assign {f_xy_zero, f_z_neg, f_z_zero, f_abs_z, f_az} = g2_side;

    always_comb begin
        if (g2_u >= HALF_TURN) begin
            f_clamp = '0;
        end else if (g2_u > QUARTER_TURN) begin
            f_clamp = QUARTER_TURN;
        end else begin
            f_clamp = g2_u;
        end
        f_theta = f_z_neg ? HALF_TURN - f_clamp : f_clamp;
        f_az_rnd = f_az + (ACC_BITS'(1) << (ACC_BITS - 1 - ANGLE_BITS));
        f_th_rnd = f_theta + (ACC_BITS'(1) << (ACC_BITS - 1 - ANGLE_BITS));
        f_rad = (g2_r + (DW'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (f_xy_zero) begin
            n_azim = '0;
            if (f_z_zero) begin
                n_radius = '0;
                n_polar = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
            end else begin
                n_radius = f_abs_z;
                n_polar = f_z_neg ? ANGLE_BITS'(1) << (ANGLE_BITS - 1) : '0;
            end
        end else begin
            n_azim = f_az_rnd[ACC_BITS-1 -: ANGLE_BITS];
            n_polar = f_th_rnd[ACC_BITS-1 -: ANGLE_BITS];
            if (f_rad[DW-1:COORD_BITS] != '0) begin
                n_radius = '1;
            end else begin
                n_radius = f_rad[COORD_BITS-1:0];
            end
        end
    end

    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_radius;
    logic [ANGLE_BITS-1:0] r_polar, r_azim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= g2_valid;
        end
        r_radius <= n_radius;
        r_polar <= n_polar;
        r_azim <= n_azim;
    end

    assign o_valid = r_o_valid;
    assign o_radius = r_radius;
    assign o_polar_angle = r_polar;
    assign o_azimuth = r_azim;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("transfer did not produce a result at the pipeline latency");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(a_valid[CORDIC_STAGES], CORDIC_STAGES + 3))
        else $error("result without an item in the azimuth pass");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_polar_angle <= (ANGLE_BITS'(1) << (ANGLE_BITS - 1))))
        else $error("polar angle beyond half a turn");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && busy)
        else $error("pipeline not cleared by reset");

endmodule

FILE: dv/tb_cartesian_to_spherical_cordic_unit.sv
// Testbench for the Cartesian to spherical CORDIC converter with its own predictor.
`timescale 1ns / 1ps

module tb_cartesian_to_spherical_cordic_unit;
    import c2s_pkg::*;

    localparam int CB = 24;
    localparam int AB = 24;
    localparam int NSTAGE = 24;
    localparam int GB = 8;
    localparam int LATENCY = 2 * NSTAGE + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1630;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] z;
    } point_t;

    typedef struct packed {
        logic [CB-1:0] radius;
        logic [AB-1:0] polar;
        logic [AB-1:0] azimuth;
    } sphere_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [CB-1:0] i_x_coord = '0;
    logic [CB-1:0] i_y_coord = '0;
    logic [CB-1:0] i_z_coord = '0;
    logic          o_valid;
    logic [CB-1:0] o_radius;
    logic [AB-1:0] o_polar_angle;
    logic [AB-1:0] o_azimuth;

    cartesian_to_spherical_cordic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord), .i_z_coord(i_z_coord),
        .o_valid(o_valid), .o_radius(o_radius), .o_polar_angle(o_polar_angle),
        .o_azimuth(o_azimuth)
    );

    always #6 i_clk = ~i_clk;

    point_t  point_queue[$];
    sphere_t sphere_queue[$];
    logic [63:0] atan_table[NSTAGE];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    bit  hold_for_drain = 1'b0;
    bit  stimulus_done = 1'b0;

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] cordic_vector(inout logic signed [63:0] vx,
                                                  inout logic signed [63:0] vy);
        logic [63:0] acc;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        acc = '0;
        for (int i = 0; i < NSTAGE; i++) begin
            xs = floor_shift(vx, i);
            ys = floor_shift(vy, i);
            if (vy >= 0) begin
                vx = vx + ys;
                vy = vy - xs;
                acc = acc + atan_table[i];
            end else begin
                vx = vx - ys;
                vy = vy + xs;
                acc = acc - atan_table[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] apply_gain(logic [63:0] v);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = v >> 32;
        lo = v & 64'hFFFF_FFFF;
        return hi * 64'(GAIN_Q32) + ((lo * 64'(GAIN_Q32) + (64'd1 << 31)) >> 32);
    endfunction

    function automatic logic [AB-1:0] round_angle(logic [63:0] a);
        logic [63:0] r;
        r = (a + (64'd1 << (63 - AB))) >> (64 - AB);
        return r[AB-1:0];
    endfunction

    function automatic sphere_t convert_point(point_t p);
        sphere_t r;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] az_x;
        logic signed [63:0] az_y;
        logic signed [63:0] el_x;
        logic signed [63:0] el_y;
        logic [63:0] az;
        logic [63:0] u;
        logic [63:0] a;
        logic [63:0] theta;
        logic [63:0] rad;
        x = 64'(signed'(p.x));
        y = 64'(signed'(p.y));
        z = 64'(signed'(p.z));
        if (x == 0 && y == 0) begin
            if (z == 0) begin
                r.radius = '0;
                r.polar = AB'(1) << (AB - 2);
            end else begin
                r.radius = CB'(z < 0 ? -z : z);
                r.polar = z > 0 ? '0 : AB'(1) << (AB - 1);
            end
            r.azimuth = '0;
            return r;
        end
        az = '0;
        az_x = x;
        az_y = y;
        if (x < 0) begin
            az_x = -x;
            az_y = -y;
            az = HALF_TURN;
        end
        az_x = az_x <<< GB;
        az_y = az_y <<< GB;
        az = az + cordic_vector(az_x, az_y);
        el_x = (z < 0 ? -z : z) <<< GB;
        el_y = apply_gain(az_x);
        u = cordic_vector(el_x, el_y);
        if (u >= HALF_TURN) begin
            a = '0;
        end else if (u > QUARTER_TURN) begin
            a = QUARTER_TURN;
        end else begin
            a = u;
        end
        theta = z < 0 ? HALF_TURN - a : a;
        rad = (apply_gain(el_x) + (64'd1 << (GB - 1))) >> GB;
        if (rad > 64'((1 << CB) - 1)) begin
            rad = 64'((1 << CB) - 1);
        end
        r.radius = rad[CB-1:0];
        r.polar = round_angle(theta);
        r.azimuth = round_angle(az);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [CB-1:0] random_coord();
        case ($urandom_range(0, 5))
            0: return CB'($urandom_range(0, 3)) - CB'(1);
            1: return CB'(1) << (CB - 1);
            2: return ~(CB'(1) << (CB - 1));
            3: return CB'($urandom_range(0, 255)) - CB'(128);
            default: return CB'($urandom);
        endcase
    endfunction

    initial begin
        localparam logic [CB-1:0] MAXP = 24'h7FFFFF;
        localparam logic [CB-1:0] MAXN = 24'h800000;
        logic [CB-1:0] edge_vals[6];
        for (int i = 0; i < NSTAGE; i++) begin
            atan_table[i] = stage_angle(i);
        end
        edge_vals = '{24'd0, 24'd1, 24'hFFFFFF, MAXP, MAXN, 24'hFFFF80};
        point_queue.push_back('{24'd0, 24'd0, 24'd0});
        point_queue.push_back('{24'd0, 24'd0, MAXP});
        point_queue.push_back('{24'd0, 24'd0, MAXN});
        point_queue.push_back('{24'd0, 24'd0, 24'hFFFFFF});
        point_queue.push_back('{MAXN, MAXN, MAXN});
        point_queue.push_back('{MAXP, MAXP, MAXP});
        point_queue.push_back('{MAXN, 24'd0, 24'd0});
        point_queue.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'd0});
        point_queue.push_back('{24'd1000, 24'hFFFFFF, 24'd5});
        point_queue.push_back('{24'hFFFFF0, 24'd0, 24'hFFFFF0});
        point_queue.push_back('{24'd0, 24'd1, 24'd0});
        point_queue.push_back('{24'd1, 24'd0, 24'hFFFFFF});
        for (int i = 0; i < 12; i++) begin
            point_queue.push_back('{edge_vals[$urandom_range(0, 5)],
                                    edge_vals[$urandom_range(0, 5)],
                                    edge_vals[$urandom_range(0, 5)]});
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            point_queue.push_back('{random_coord(), random_coord(), random_coord()});
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sphere_queue.push_back(convert_point('{i_x_coord, i_y_coord, i_z_coord}));
                void'(point_queue.pop_front());
                if (point_queue.size() == 800) begin
                    hold_for_drain <= 1'b1;
                end
                if (point_queue.size() > 0 && $urandom_range(0, 2) != 0
                        && !hold_for_drain && point_queue.size() != 800) begin
                    start <= 1'b1;
                    {i_x_coord, i_y_coord, i_z_coord} <= point_queue[0];
                end else begin
                    start <= 1'b0;
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                    if (point_queue.size() == 0) begin
                        stimulus_done <= 1'b1;
                    end
                end
            end else if (!start && !stimulus_done) begin
                if (hold_for_drain) begin
                    if (sphere_queue.size() == 0) begin
                        hold_for_drain <= 1'b0;
                    end
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (point_queue.size() > 0) begin
                    start <= 1'b1;
                    {i_x_coord, i_y_coord, i_z_coord} <= point_queue[0];
                end
            end
        end
    end

    always @(posedge i_clk) begin
        sphere_t want;
        if (i_rst_n && o_valid) begin
            if (sphere_queue.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end else begin
                want = sphere_queue.pop_front();
                if (o_radius !== want.radius) begin
                    report_mismatch("radius", 32'(o_radius), 32'(want.radius));
                end
                if (o_polar_angle !== want.polar) begin
                    report_mismatch("polar_angle", 32'(o_polar_angle), 32'(want.polar));
                end
                if (o_azimuth !== want.azimuth) begin
                    report_mismatch("azimuth", 32'(o_azimuth), 32'(want.azimuth));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (sphere_queue.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (error_count == 0 && sphere_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
